[rtl/core/e2q_pkg.sv]
// Package for the Euler angle to quaternion converter.
// Holds payload types, CORDIC constants and the arctangent table; no dependencies.
package e2q_pkg;

    localparam int ANGLE_BITS_DEF     = 16;
    localparam int COMPONENT_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF   = 16;

    localparam int CW = 34;                  // CORDIC x/y width, Q30 plus growth
    localparam int ZW = 33;                  // phase accumulator, 2^32 per turn
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
    } e2q_in_t;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } e2q_out_t;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B; 5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53; 5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9; 5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return $signed({1'b0, v});
    endfunction

endpackage

[rtl/core/e2q_cordic.sv]
// One rotation-mode CORDIC micro-rotation stage, registered, with stall.
// Depends on e2q_pkg.
module e2q_cordic
    import e2q_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [ZW-1:0] z_out
);
    logic signed [CW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0] z_reg, z_next, at;
    logic signed [CW-1:0] dx, dy;

    always_comb
    begin
        at = atan_lut(5'(STEP));
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (!z_in[ZW-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - at;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

[rtl/core/euler_to_quaternion.sv]
// Top level of the Euler yaw/pitch/roll to quaternion converter.
// Depends on e2q_pkg and e2q_cordic.
//
//  channel | fields                              | handshake
//  in      | yaw_angle, pitch_angle, roll_angle  | in_valid / in_stall
//  out     | quat_x, quat_y, quat_z, quat_w      | out_valid / out_stall
//
// One beat per cycle sustained while no output stall holds the pipe. A result
// on out_data has passed CORDIC_STEPS + 5 registers, with CORDIC_STEPS capped
// at 32: one input register, one CORDIC stage per step,
// two product levels for the triple products, one sum stage and the output
// register (round and saturate).
// Reset clears only the valid bits. The whole pipe advances together; a
// stall on the output holds every stage, bubbles included, and in_stall
// follows it only when the output register is full.
module euler_to_quaternion
    import e2q_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  e2q_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output e2q_out_t out_data
);
    localparam int NS    = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int DEPTH = NS + 4;      // valid bits before output register

    logic en;
    logic [DEPTH-1:0] vld_reg;
    logic             out_valid_reg;

    // pipe moves unless the output is full and stalled
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[DEPTH-2:0], in_valid};
            out_valid_reg <= vld_reg[DEPTH-1];
        end
    end
    assign out_valid = out_valid_reg;

    // input register: half angle in 2^32 units, floor of angle*2^16/2
    logic signed [ZW-1:0] z0_reg [3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg[0] <= ZW'({{(ZW-31){in_data.yaw_angle[15]}}, in_data.yaw_angle, 15'd0});
            z0_reg[1] <= ZW'({{(ZW-31){in_data.pitch_angle[15]}}, in_data.pitch_angle, 15'd0});
            z0_reg[2] <= ZW'({{(ZW-31){in_data.roll_angle[15]}}, in_data.roll_angle, 15'd0});
        end
    end

    // three CORDIC chains
    logic signed [CW-1:0] cs [3];
    logic signed [CW-1:0] sn [3];
    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        logic signed [CW-1:0] xs [NS+1];
        logic signed [CW-1:0] ys [NS+1];
        logic signed [ZW-1:0] zs [NS+1];
        assign xs[0] = GAIN_Q30;
        assign ys[0] = '0;
        assign zs[0] = z0_reg[a];
        for (genvar s = 0; s < NS; s++)
        begin : g_step
            e2q_cordic #(.STEP(s)) u_step (
                .clk(clk), .en(en),
                .x_in(xs[s]), .y_in(ys[s]), .z_in(zs[s]),
                .x_out(xs[s+1]), .y_out(ys[s+1]), .z_out(zs[s+1])
            );
        end
        assign cs[a] = xs[NS];
        assign sn[a] = ys[NS];
    end

    // first products, rounded to Q30: cY*cP, cY*sP, sY*cP, sY*sP
    logic signed [CW-1:0] p1_reg [4];
    logic signed [CW-1:0] r1_reg [2];   // roll cos/sin delayed
    logic signed [67:0]   m1 [4];
    always_comb
    begin
        m1[0] = 68'(cs[0]) * 68'(cs[1]) + 68'sd536870912;
        m1[1] = 68'(cs[0]) * 68'(sn[1]) + 68'sd536870912;
        m1[2] = 68'(sn[0]) * 68'(cs[1]) + 68'sd536870912;
        m1[3] = 68'(sn[0]) * 68'(sn[1]) + 68'sd536870912;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
                p1_reg[k] <= CW'(m1[k] >>> 30);
            r1_reg[0] <= cs[2];
            r1_reg[1] <= sn[2];
        end
    end

    // triple products: t[k*2+0] = p1[k]*cR, t[k*2+1] = p1[k]*sR
    logic signed [CW-1:0] t_reg [8];
    logic signed [67:0]   m2 [8];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            m2[2*k]   = 68'(p1_reg[k]) * 68'(r1_reg[0]) + 68'sd536870912;
            m2[2*k+1] = 68'(p1_reg[k]) * 68'(r1_reg[1]) + 68'sd536870912;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
            for (int k = 0; k < 8; k++)
                t_reg[k] <= CW'(m2[k] >>> 30);
    end

    // indices: 0 cYcPcR 1 cYcPsR 2 cYsPcR 3 cYsPsR 4 sYcPcR 5 sYcPsR 6 sYsPcR 7 sYsPsR
    logic signed [CW:0] sum_reg [4];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg[0] <= (CW+1)'(t_reg[2]) + (CW+1)'(t_reg[5]);
            sum_reg[1] <= (CW+1)'(t_reg[4]) - (CW+1)'(t_reg[3]);
            sum_reg[2] <= (CW+1)'(t_reg[1]) - (CW+1)'(t_reg[6]);
            sum_reg[3] <= (CW+1)'(t_reg[0]) + (CW+1)'(t_reg[7]);
        end
    end

    // round to Q1.15 and saturate
    function automatic logic signed [15:0] to_comp(input logic signed [CW:0] v);
        logic signed [CW:0] r;
        r = (v + (CW+1)'(32'sd16384)) >>> 15;
        if (r > (CW+1)'(32'sd32767))
            return 16'sd32767;
        else if (r < -(CW+1)'(32'sd32768))
            return -16'sd32768;
        else
            return r[15:0];
    endfunction

    e2q_out_t out_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.quat_x <= to_comp(sum_reg[0]);
            out_reg.quat_y <= to_comp(sum_reg[1]);
            out_reg.quat_z <= to_comp(sum_reg[2]);
            out_reg.quat_w <= to_comp(sum_reg[3]);
        end
    end
    assign out_data = out_reg;
endmodule
